// ----- src/fau_pkg.sv -----
// ============================================================================
// fau_pkg: shared types and constants of the fraction arithmetic unit
// Operation and status codes, widths and the sequencer state type.
// ============================================================================
package fau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int IN_W          = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH + 2;
    localparam int CNT_W         = $clog2(MAG_W + 1);

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_COMBINE,
        S_GCD,
        S_DIVIDE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic       done;
    } t_hs;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] first_num;
        logic [15:0] first_den;
        logic [15:0] second_num;
        logic [15:0] second_den;
    } t_in_item;

    typedef struct packed {
        logic [32:0] whole_part;
        logic [31:0] rem_num;
        logic [31:0] res_den;
        logic [1:0]  status;
    } t_out_item;

endpackage

// ----- src/fau_if.sv -----
// ============================================================================
// fau_in_if / fau_out_if: valid-ready channels of the fraction unit
// Each carries valid, ready and one item of payload.
// ============================================================================
interface fau_in_if;
    logic                  valid;
    logic                  ready;
    fau_pkg::t_in_item     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fau_out_if;
    logic                  valid;
    logic                  ready;
    fau_pkg::t_out_item    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/fau_divider.sv -----
// ============================================================================
// fau_divider: bit-serial restoring divider
// Produces quotient and remainder of two magnitudes, one bit per cycle.
// ============================================================================
module fau_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fau_pkg::MAG_W-1:0]   i_dividend,
    input  logic [fau_pkg::MAG_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [fau_pkg::MAG_W-1:0]   o_quot,
    output logic [fau_pkg::MAG_W-1:0]   o_rem
);
    import fau_pkg::*;

    logic [MAG_W-1:0] r_quot, r_rem, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [MAG_W:0]   w_trial;
    logic [MAG_W:0]   w_diff;

    // Shift in the next dividend bit and try a subtraction.
    assign w_trial = {r_rem, r_quot[MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!w_diff[MAG_W]) begin
                    r_rem  <= w_diff[MAG_W-1:0];
                    r_quot <= {r_quot[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial[MAG_W-1:0];
                    r_quot <= {r_quot[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- src/fraction_arith_unit.sv -----
// ============================================================================
// fraction_arith_unit: exact add, subtract, multiply, divide of fractions
// Reduces operands and result by gcd and splits the result into a whole
// part and a remainder, using one shared bit-serial divider.
// ============================================================================
// Usage: an item on i_in carries an operation code and two signed fractions.
// The unit accepts one item at a time: i_in.ready is high while the
// sequencer is idle. Each item yields exactly one result on o_out, which is
// held in the output register until the receiver raises ready; the unit does
// not take the next item before that result has been taken.
// Flow: an item flagged for a zero denominator or a division by a zero
// value has its result set valid by the setup state. Otherwise the work
// is a chain of divisions on 34-bit magnitudes in the shared restoring
// divider (a registered start request, one shift per quotient bit, then a
// done strobe): Euclid's gcd steps for both operands and for the result (each
// step one division), two divisions per reduction and one final division.
// The three cross products are shift-and-add. The number of Euclid steps
// sets the time: up to about 24 per operand gcd and about 47 for the
// result gcd. The next item can be taken in the cycle after the result has
// been accepted.
// Reset: synchronous, active low; it returns the sequencer to idle and drops
// the output valid. A stalled receiver simply holds the result in place.
// ============================================================================
module fraction_arith_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    fau_in_if.sink    i_in,
    fau_out_if.source o_out
);
    import fau_pkg::*;

    // Task list: each gcd job reduces one num/den pair in the register file.
    typedef enum logic [2:0] {
        J_OPA, J_OPB, J_RES
    } t_job;

    typedef enum logic [3:0] {
        P_EUCLID, P_DIVN, P_DIVD, P_SPLIT
    } t_phase;

    t_state          r_state, n_state;
    t_phase          r_phase;
    t_job            r_job;
    logic [1:0]      r_func;
    // Sign-magnitude values: operand a, operand b, result.
    logic            r_an_s, r_ad_s, r_bn_s, r_bd_s, r_rn_s, r_rd_s;
    logic [MAG_W-1:0] r_an, r_ad, r_bn, r_bd, r_rn, r_rd;
    logic [MAG_W-1:0] r_ga, r_gb;        // Euclid pair
    logic [MAG_W-1:0] r_g;               // gcd found
    // Serial multiplier
    logic [MAG_W-1:0] r_mc, r_mp, r_acc;
    logic [CNT_W-1:0] r_mcnt;
    logic [1:0]      r_midx;
    logic [MAG_W-1:0] r_p0, r_p1, r_p2;
    logic            r_s0, r_s1, r_s2;
    t_out_item       r_out;
    logic            r_ovalid;

    // A division request is registered, so that the division starts on the
    // operands the sequencer has just written.
    logic            r_dgo, n_dgo;
    logic [MAG_W-1:0] w_dvd, w_dvs;
    logic            w_ddone;
    logic [MAG_W-1:0] w_quot, w_rem;
    t_hs             w_hs;
    logic            w_zden;

    fau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_ddone),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    function automatic logic [MAG_W-1:0] f_mag(input logic [IN_W-1:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        begin
            t = v[OPERAND_WIDTH-1:0];
            if (t[OPERAND_WIDTH-1]) t = -t;
            f_mag = MAG_W'(t) | (v[OPERAND_WIDTH-1] && t == '0
                    ? MAG_W'(1) << (OPERAND_WIDTH-1) : '0);
        end
    endfunction

    assign w_hs.start = i_in.valid && i_in.ready;
    assign w_hs.done  = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
    assign w_zden = (r_ad == '0 || r_bd == '0);

    // Divider operands follow the current gcd phase.
    always_comb begin
        w_dvd = r_ga;
        w_dvs = r_gb;
        unique case (r_phase)
            P_EUCLID: begin w_dvd = r_ga; w_dvs = r_gb; end
            P_DIVN:   begin
                w_dvd = (r_job == J_OPA) ? r_an : (r_job == J_OPB) ? r_bn : r_rn;
                w_dvs = r_g;
            end
            P_DIVD:   begin
                w_dvd = (r_job == J_OPA) ? r_ad : (r_job == J_OPB) ? r_bd : r_rd;
                w_dvs = r_g;
            end
            P_SPLIT:  begin w_dvd = r_rn; w_dvs = r_rd; end
            default:  begin w_dvd = r_ga; w_dvs = r_gb; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dgo   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dgo   <= n_dgo;
        end
    end

    // Next state and division requests; datapath updates are in the clocked
    // block below.
    always_comb begin
        n_state = r_state;
        n_dgo   = 1'b0;
        unique case (r_state)
            S_IDLE:    if (w_hs.start) n_state = S_SETUP;
            S_SETUP: begin
                if (w_zden || (r_func == FUNC_DIV && r_bn == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_GCD;
                    n_dgo   = 1'b1;
                end
            end
            S_GCD: begin
                if (w_ddone) begin
                    priority if (r_phase == P_SPLIT)
                        n_state = S_OUT;
                    else if (r_phase == P_DIVD && r_job == J_OPB)
                        n_state = S_MUL;
                    else
                        n_dgo = 1'b1;
                end
            end
            S_MUL:     if (r_midx == 2'd2 && r_mcnt == '0) n_state = S_COMBINE;
            S_COMBINE: begin
                n_state = S_GCD;
                n_dgo   = 1'b1;
            end
            S_OUT:     if (w_hs.done) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Multiply operand select: three products for the cross formulas.
    logic [MAG_W-1:0] w_ma, w_mb;
    logic             w_ms;
    always_comb begin
        unique case (r_midx)
            2'd0: begin
                w_ma = r_an;
                w_mb = (r_func == FUNC_MUL) ? r_bn : r_bd;
                w_ms = r_an_s ^ ((r_func == FUNC_MUL) ? r_bn_s : r_bd_s);
            end
            2'd1: begin
                w_ma = r_ad;
                w_mb = (r_func == FUNC_MUL) ? r_bd : r_bn;
                w_ms = r_ad_s ^ ((r_func == FUNC_MUL) ? r_bd_s : r_bn_s);
            end
            default: begin
                w_ma = r_ad;
                w_mb = r_bd;
                w_ms = r_ad_s ^ r_bd_s;
            end
        endcase
    end

    // Signed sum of the two cross products for add and subtract.
    logic             w_q_s, w_sum_s;
    logic [MAG_W-1:0] w_sum;
    always_comb begin
        w_q_s = r_s1 ^ (r_func == FUNC_SUB);
        if (r_s0 == w_q_s) begin
            w_sum = r_p0 + r_p1; w_sum_s = r_s0;
        end else if (r_p0 >= r_p1) begin
            w_sum = r_p0 - r_p1; w_sum_s = r_s0;
        end else begin
            w_sum = r_p1 - r_p0; w_sum_s = w_q_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_phase  <= P_EUCLID;
            r_job    <= J_OPA;
            r_midx   <= 2'd0;
            r_mcnt   <= '0;
            r_func   <= FUNC_ADD;
        end else begin
            if (w_hs.done) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_hs.start) begin
                        r_func <= i_in.data.func;
                        r_an   <= f_mag(i_in.data.first_num);
                        r_ad   <= f_mag(i_in.data.first_den);
                        r_bn   <= f_mag(i_in.data.second_num);
                        r_bd   <= f_mag(i_in.data.second_den);
                        r_an_s <= i_in.data.first_num[OPERAND_WIDTH-1];
                        r_ad_s <= i_in.data.first_den[OPERAND_WIDTH-1];
                        r_bn_s <= i_in.data.second_num[OPERAND_WIDTH-1];
                        r_bd_s <= i_in.data.second_den[OPERAND_WIDTH-1];
                        r_ga   <= f_mag(i_in.data.first_den);
                        r_gb   <= f_mag(i_in.data.first_num);
                        r_job  <= J_OPA;
                        r_phase <= P_EUCLID;
                    end
                end
                S_SETUP: begin
                    if (w_zden || (r_func == FUNC_DIV && r_bn == '0)) begin
                        r_out.whole_part <= '0;
                        r_out.rem_num    <= '0;
                        r_out.res_den    <= '0;
                        r_out.status     <= w_zden ? ST_ZERO_DEN : ST_DIV_ZERO;
                        r_ovalid         <= 1'b1;
                    end else if (r_gb == '0) begin
                        // Zero numerator: the gcd is the denominator itself.
                        r_g     <= r_ga;
                        r_phase <= P_DIVN;
                    end
                end
                S_GCD: begin
                    if (w_ddone) begin
                        unique case (r_phase)
                            P_EUCLID: begin
                                r_ga <= r_gb;
                                r_gb <= w_rem;
                                if (w_rem == '0) begin
                                    r_g     <= r_gb;
                                    r_phase <= P_DIVN;
                                end
                            end
                            P_DIVN: begin
                                unique case (r_job)
                                    J_OPA:   r_an <= w_quot;
                                    J_OPB:   r_bn <= w_quot;
                                    default: r_rn <= w_quot;
                                endcase
                                r_phase <= P_DIVD;
                            end
                            P_DIVD: begin
                                unique case (r_job)
                                    J_OPA: begin
                                        r_ad    <= w_quot;
                                        r_job   <= J_OPB;
                                        r_ga    <= r_bd;
                                        r_gb    <= r_bn;
                                        if (r_bn == '0) begin
                                            r_g     <= r_bd;
                                            r_phase <= P_DIVN;
                                        end else r_phase <= P_EUCLID;
                                    end
                                    J_OPB: begin
                                        r_bd   <= w_quot;
                                        r_midx <= 2'd0;
                                        r_mcnt <= CNT_W'(MAG_W);
                                        r_acc  <= '0;
                                    end
                                    default: begin
                                        r_rd    <= w_quot;
                                        r_phase <= P_SPLIT;
                                    end
                                endcase
                            end
                            default: begin
                                r_out.whole_part <= 33'((r_rn_s != r_rd_s) ? -w_quot : w_quot);
                                r_out.rem_num    <= 32'(r_rn_s ? -w_rem : w_rem);
                                r_out.res_den    <= 32'(r_rd_s ? -r_rd : r_rd);
                                r_out.status     <= ST_OK;
                                r_ovalid         <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    // Shift-and-add, one multiplier bit per cycle, most
                    // significant bit first; the load cycle handles the top bit.
                    if (r_mcnt == CNT_W'(MAG_W)) begin
                        r_mc   <= w_ma;
                        r_mp   <= w_mb << 1;
                        r_acc  <= w_mb[MAG_W-1] ? w_ma : '0;
                        r_mcnt <= r_mcnt - 1'b1;
                    end else if (r_mcnt != '0) begin
                        r_acc  <= (r_acc << 1) + (r_mp[MAG_W-1] ? r_mc : '0);
                        r_mp   <= r_mp << 1;
                        r_mcnt <= r_mcnt - 1'b1;
                    end else begin
                        unique case (r_midx)
                            2'd0:    begin r_p0 <= r_acc; r_s0 <= w_ms; end
                            2'd1:    begin r_p1 <= r_acc; r_s1 <= w_ms; end
                            default: begin r_p2 <= r_acc; r_s2 <= w_ms; end
                        endcase
                        r_midx <= r_midx + 2'd1;
                        r_mcnt <= CNT_W'(MAG_W);
                    end
                end
                S_COMBINE: begin
                    r_job <= J_RES;
                    if (r_func == FUNC_MUL || r_func == FUNC_DIV) begin
                        r_rn <= r_p0; r_rn_s <= r_s0;
                        r_rd <= r_p1; r_rd_s <= r_s1;
                        r_ga <= r_p1; r_gb <= r_p0;
                        if (r_p0 == '0) begin r_g <= r_p1; r_phase <= P_DIVN; end
                        else r_phase <= P_EUCLID;
                    end else begin
                        r_rn <= w_sum; r_rn_s <= w_sum_s;
                        r_rd <= r_p2; r_rd_s <= r_s2;
                        r_ga <= r_p2; r_gb <= w_sum;
                        if (w_sum == '0) begin r_g <= r_p2; r_phase <= P_DIVN; end
                        else r_phase <= P_EUCLID;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- src/fau_checker.sv -----
// ============================================================================
// fau_checker: port-level checks of the fraction arithmetic unit
// Watches the handshakes and result encoding; bound to the top level.
// ============================================================================
module fau_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input fau_pkg::t_out_item  i_out_data
);
    import fau_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result waits");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |->
        i_out_data.whole_part == '0 && i_out_data.res_den == '0)
        else $error("error result carries data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status <= ST_DIV_ZERO)
        else $error("undefined status");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result appeared the cycle after accept");

endmodule

bind fraction_arith_unit fau_checker u_fau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: regression bench for fraction_arith_unit
// Directed and random fraction items are driven into the unit over a
// valid-ready channel, the results are checked field by field against a
// behavioral model of the arithmetic, with random idling on both sides.
// ============================================================================
module tb;
    import fau_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fau_in_if  in_ch ();
    fau_out_if out_ch ();

    fraction_arith_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Items waiting to be offered, and results the unit still owes us.
    t_in_item  pending_items[$];
    t_out_item owed_results[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  status_seen[3] = '{0, 0, 0};
    bit  in_taken = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_cycles = 0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  quiet = 1'b0;

    // Greatest common divisor of two nonnegative values.
    function automatic longint gcd_of(longint a, longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact fraction arithmetic with gcd reduction. Reducing by the gcd of
    // magnitudes keeps each sign where it was, and SystemVerilog division
    // and modulo truncate the same way the unit does.
    function automatic t_out_item predict_fraction(t_in_item it);
        longint an, ad, bn, bd, num, den, g;
        longint whole, rem;
        t_out_item res;
        res = '0;
        an = longint'($signed(it.first_num));
        ad = longint'($signed(it.first_den));
        bn = longint'($signed(it.second_num));
        bd = longint'($signed(it.second_den));
        if (ad == 0 || bd == 0) begin
            res.status = ST_ZERO_DEN;
            return res;
        end
        if (t_func'(it.func) == FUNC_DIV && bn == 0) begin
            res.status = ST_DIV_ZERO;
            return res;
        end
        g = gcd_of(mag_of(an), mag_of(ad));
        an = an / g;
        ad = ad / g;
        g = gcd_of(mag_of(bn), mag_of(bd));
        bn = bn / g;
        bd = bd / g;
        case (t_func'(it.func))
            FUNC_ADD: begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            FUNC_SUB: begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            FUNC_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        // A zero numerator leaves the denominator at +1 or -1.
        g = gcd_of(mag_of(num), mag_of(den));
        num = num / g;
        den = den / g;
        whole = num / den;
        rem = num % den;
        res.whole_part = whole[32:0];
        res.rem_num = rem[31:0];
        res.res_den = den[31:0];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic t_in_item make_item(t_func f, int an, int ad, int bn, int bd);
        t_in_item it;
        it.func = f;
        it.first_num = an[15:0];
        it.first_den = ad[15:0];
        it.second_num = bn[15:0];
        it.second_den = bd[15:0];
        return it;
    endfunction

    // One random operand: full range, small values or extremes.
    function automatic logic [15:0] rand_operand();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom);
            4, 5, 6: v = 16'($signed($urandom_range(0, 40)) - 20);
            7: v = 16'($signed($urandom_range(0, 400)) - 200);
            8: v = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: v = 16'($signed($urandom_range(0, 2)) - 1);
        endcase
        return v;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.func = 2'($urandom_range(0, 3));
        it.first_num = rand_operand();
        it.first_den = rand_operand();
        it.second_num = rand_operand();
        it.second_den = rand_operand();
        // Keep zero denominators rare so most items do real work.
        if (it.first_den == 0 && $urandom_range(0, 3) != 0) it.first_den = 16'd1;
        if (it.second_den == 0 && $urandom_range(0, 3) != 0) it.second_den = 16'hFFFF;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || owed_results.size() != 0 || in_ch.valid)
            @(posedge i_clk);
    endtask

    // Acceptance is seen at the rising edge; the expected result is
    // computed from the item the unit actually took.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            owed_results.push_back(predict_fraction(in_ch.data));
            void'(pending_items.pop_front());
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Sender: a held item stays up until taken; otherwise idle in random
    // bursts or present the next item from the queue.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else if (in_ch.valid && !in_taken) begin
            in_ch.valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 2);
            in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending_items[0];
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            hold_cycles <= 600;
            long_hold_done <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Receiver ready, with random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0 || (long_hold_req && !long_hold_done)) begin
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            recv_gap <= $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
            end else begin
                want = owed_results.pop_front();
                if (want.status <= ST_DIV_ZERO) status_seen[want.status]++;
                if (got.whole_part !== want.whole_part || got.rem_num !== want.rem_num ||
                    got.res_den !== want.res_den || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d expected whole=%0d rem=%0d den=%0d st=%0d,",
                                  " got whole=%0d rem=%0d den=%0d st=%0d"},
                                 results_seen, $signed(want.whole_part),
                                 $signed(want.rem_num), $signed(want.res_den), want.status,
                                 $signed(got.whole_part), $signed(got.rem_num),
                                 $signed(got.res_den), got.status);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items: every operation, extremes, error cases.
        pending_items.push_back(make_item(FUNC_ADD, 1, 2, 1, 3));
        pending_items.push_back(make_item(FUNC_SUB, 1, 2, 1, 2));
        pending_items.push_back(make_item(FUNC_MUL, -3, 4, 2, -9));
        pending_items.push_back(make_item(FUNC_DIV, 7, 3, -2, 5));
        pending_items.push_back(make_item(FUNC_ADD, 5, 0, 1, 1));
        pending_items.push_back(make_item(FUNC_MUL, 5, 3, 1, 0));
        pending_items.push_back(make_item(FUNC_DIV, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_DIV, 5, 3, 0, 7));
        pending_items.push_back(make_item(FUNC_DIV, 5, 3, 0, -7));
        pending_items.push_back(make_item(FUNC_DIV, 5, 3, 4, 2));
        pending_items.push_back(make_item(FUNC_DIV, -9, 4, -6, 3));
        pending_items.push_back(make_item(FUNC_MUL, 0, -5, 3, 7));
        pending_items.push_back(make_item(FUNC_ADD, 0, 5, 0, -3));
        pending_items.push_back(make_item(FUNC_ADD, 32767, 1, 32767, 1));
        pending_items.push_back(make_item(FUNC_SUB, -32768, 1, 32767, 1));
        pending_items.push_back(make_item(FUNC_MUL, -32768, 1, -32768, 1));
        pending_items.push_back(make_item(FUNC_DIV, -32768, 1, 1, 32767));
        pending_items.push_back(make_item(FUNC_DIV, 1, -32768, 32767, 1));
        pending_items.push_back(make_item(FUNC_ADD, 32767, -32768, -32768, 32767));
        pending_items.push_back(make_item(FUNC_MUL, 32767, 32765, 32764, 32767));
        pending_items.push_back(make_item(FUNC_SUB, -7, -3, 2, -3));
        pending_items.push_back(make_item(FUNC_ADD, -1, -1, -1, -1));
        wait_drained();

        for (int i = 0; i < 700; i++) pending_items.push_back(rand_item());
        // The bench waits here until every item is sent and every owed result is back.
        wait_drained();

        // Receiver holds off while the sender keeps offering items.
        long_hold_req = 1'b1;
        for (int i = 0; i < 800; i++) pending_items.push_back(rand_item());
        while (pending_items.size() > 200) @(posedge i_clk);
        quiet = 1'b1;
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d zero denominator, %0d divide by zero.",
                 results_seen, status_seen[0], status_seen[1], status_seen[2]);
        $display("Covered all operations, operand extremes and stall patterns on both sides.");
        if (mismatches == 0) begin
            $display("fraction_arith_unit regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("fraction_arith_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Timeout with %0d results still owed", owed_results.size());
        $display("fraction_arith_unit regression: fail");
        $finish;
    end

endmodule
